// ----- design/prime_sieve_counter_assert.svh -----
// Assertion macros used by the engine design file.
`ifndef PRIME_SIEVE_COUNTER_ASSERT_SVH
`define PRIME_SIEVE_COUNTER_ASSERT_SVH

`ifndef ASSERT_OFF
`define PSC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PSC_ASSERT_NEVER(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("forbidden condition seen");
`else
`define PSC_ASSERT(label, clk, rst_n, prop)
`define PSC_ASSERT_NEVER(label, clk, rst_n, prop)
`endif

`endif

// ----- design/psc_pkg.sv -----
package psc_pkg;

    localparam int NUM_W = 12;
    localparam int CTR_W = NUM_W + 1;

    localparam logic [NUM_W-1:0] CNT_MAX = '1;

    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_NO_SIEVE    = 2'd1;
    localparam logic [1:0] STATUS_ABOVE_LIMIT = 2'd2;

    localparam logic REG_RANGE_LOW  = 1'b0;
    localparam logic REG_RANGE_HIGH = 1'b1;

    localparam logic [NUM_W-1:0] RANGE_LOW_RESET  = 12'd2;
    localparam logic [NUM_W-1:0] RANGE_HIGH_RESET = 12'd4095;

    typedef struct packed {
        logic             operation;
        logic [NUM_W-1:0] number;
        logic [NUM_W-1:0] range_low;
        logic [NUM_W-1:0] range_high;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             is_prime;
        logic [NUM_W-1:0] prime_count;
    } result_t;

endpackage

// ----- design/prime_sieve_counter.sv -----
// Prime sieve counter: a Sieve of Eratosthenes over 2..range_high kept in a
// one-bit store, with a prime count over range_low..range_high.
// Each input beat on s_ carries an operation and a number. A build beat fills
// the store, strikes the multiples of every prime up to the square root of
// the limit and counts the survivors. A query beat looks up one number.
// Every input beat gives exactly one result beat on m_.
// The configuration port writes range_low (index 0) and range_high (index 1)
// and is to be used only while the block is idle; the block does not enforce this.
// A build of limit L clears the store over 0..L, tests each outer candidate,
// strikes each multiple of a prime candidate from its square up, and then
// counts the survivors over range_low..L.
// A flagged query goes from idle straight to the result state; any other
// query first reads the store in the query state.
// The block takes one beat at a time.
// Reset empties the output register, clears the built flag and the count and
// restores the register defaults; the store itself is not cleared.
// The result sits in an output register; when m_tready is low the next beat
// is still taken and processed, and its result waits until the register frees.
module prime_sieve_counter #(
    parameter int MAX_NUMBER = 4095
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // operation, number, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // prime_count, is_prime, status, zero pad
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [11:0] cfg_wdata
);

    logic [psc_pkg::NUM_W-1:0] range_low_reg;
    logic [psc_pkg::NUM_W-1:0] range_high_reg;
    logic                      m_tvalid_reg;
    psc_pkg::result_t          m_data_reg;

    psc_pkg::cmd_t    cmd;
    psc_pkg::result_t res;
    logic eng_ready, res_valid, res_ready, start;

    assign cmd.operation  = s_tdata[0];
    assign cmd.number     = s_tdata[12:1];
    assign cmd.range_low  = range_low_reg;
    assign cmd.range_high = range_high_reg;

    assign s_tready  = eng_ready;
    assign start     = s_tvalid && eng_ready;
    assign res_ready = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_data_reg};

    psc_engine #(
        .MAX_NUMBER(MAX_NUMBER)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .cmd       (cmd),
        .ready     (eng_ready),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_low_reg  <= psc_pkg::RANGE_LOW_RESET;
            range_high_reg <= psc_pkg::RANGE_HIGH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                psc_pkg::REG_RANGE_LOW:  range_low_reg  <= cfg_wdata;
                psc_pkg::REG_RANGE_HIGH: range_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res;
        end
    end

endmodule

// ----- design/psc_engine.sv -----
`include "prime_sieve_counter_assert.svh"

module psc_engine #(
    parameter int MAX_NUMBER = 4095
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  psc_pkg::cmd_t    cmd,
    output logic             ready,
    output logic             res_valid,
    output psc_pkg::result_t res,
    input  logic             res_ready
);

    localparam int CAP_NUM = (MAX_NUMBER < 4095) ? MAX_NUMBER : 4095;
    localparam int DEPTH   = CAP_NUM + 1;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam logic [psc_pkg::NUM_W-1:0] LIMIT_CAP = psc_pkg::NUM_W'(CAP_NUM);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLEAR  = 3'd1;
    localparam logic [2:0] ST_OUTER  = 3'd2;
    localparam logic [2:0] ST_TEST   = 3'd3;
    localparam logic [2:0] ST_STRIKE = 3'd4;
    localparam logic [2:0] ST_COUNT  = 3'd5;
    localparam logic [2:0] ST_QUERY  = 3'd6;
    localparam logic [2:0] ST_RESULT = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [psc_pkg::CTR_W-1:0] i_reg, i_next;
    logic [psc_pkg::CTR_W-1:0] j_reg, j_next;
    logic [psc_pkg::NUM_W-1:0] limit_reg, limit_next;
    logic [psc_pkg::NUM_W-1:0] low_reg, low_next;
    logic [psc_pkg::NUM_W-1:0] count_reg, count_next;
    logic pend_reg, pend_next;
    logic built_reg, built_next;
    logic [psc_pkg::NUM_W-1:0] built_limit_reg, built_limit_next;
    logic [psc_pkg::NUM_W-1:0] last_count_reg, last_count_next;
    psc_pkg::result_t res_reg, res_next;

    logic mem [DEPTH];
    logic rd_data_reg;
    logic mem_we, mem_wdata, mem_re;
    logic [psc_pkg::CTR_W-1:0] mem_waddr, mem_raddr;

    logic [2*psc_pkg::CTR_W-1:0] square;
    logic [psc_pkg::CTR_W-1:0] limit_ext;

    assign square    = i_reg * i_reg;
    assign limit_ext = {1'b0, limit_reg};
    assign ready     = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESULT);
    assign res       = res_reg;

    always_comb begin
        state_next       = state_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        limit_next       = limit_reg;
        low_next         = low_reg;
        count_next       = count_reg;
        pend_next        = pend_reg;
        built_next       = built_reg;
        built_limit_next = built_limit_reg;
        last_count_next  = last_count_reg;
        res_next         = res_reg;
        mem_we           = 1'b0;
        mem_wdata        = 1'b0;
        mem_waddr        = i_reg;
        mem_re           = 1'b0;
        mem_raddr        = i_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    limit_next = (cmd.range_high > LIMIT_CAP) ? LIMIT_CAP : cmd.range_high;
                    low_next   = cmd.range_low;
                    res_next.prime_count = last_count_reg;
                    res_next.is_prime    = 1'b0;
                    if (cmd.operation == psc_pkg::OP_BUILD) begin
                        i_next     = '0;
                        state_next = ST_CLEAR;
                    end else if (!built_reg) begin
                        res_next.status = psc_pkg::STATUS_NO_SIEVE;
                        state_next      = ST_RESULT;
                    end else if (cmd.number > built_limit_reg) begin
                        res_next.status = psc_pkg::STATUS_ABOVE_LIMIT;
                        state_next      = ST_RESULT;
                    end else begin
                        mem_re     = 1'b1;
                        mem_raddr  = {1'b0, cmd.number};
                        state_next = ST_QUERY;
                    end
                end
            end
            ST_QUERY: begin
                res_next.is_prime = rd_data_reg;
                res_next.status   = psc_pkg::STATUS_OK;
                state_next        = ST_RESULT;
            end
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = i_reg;
                mem_wdata = (i_reg >= psc_pkg::CTR_W'(2));
                if (i_reg == limit_ext) begin
                    i_next     = psc_pkg::CTR_W'(2);
                    state_next = ST_OUTER;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_OUTER: begin
                if (square > {{psc_pkg::CTR_W{1'b0}}, limit_ext}) begin
                    i_next     = {1'b0, low_reg};
                    count_next = '0;
                    pend_next  = 1'b0;
                    state_next = ST_COUNT;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = i_reg;
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (rd_data_reg) begin
                    j_next     = square[psc_pkg::CTR_W-1:0];
                    state_next = ST_STRIKE;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_OUTER;
                end
            end
            ST_STRIKE: begin
                if (j_reg > limit_ext) begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_OUTER;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = j_reg;
                    mem_wdata = 1'b0;
                    j_next    = j_reg + i_reg;
                end
            end
            ST_COUNT: begin
                if (pend_reg && rd_data_reg && (count_reg != psc_pkg::CNT_MAX)) begin
                    count_next = count_reg + 1'b1;
                end
                if (i_reg <= limit_ext) begin
                    mem_re    = 1'b1;
                    mem_raddr = i_reg;
                    pend_next = 1'b1;
                    i_next    = i_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        built_next           = 1'b1;
                        built_limit_next     = limit_reg;
                        last_count_next      = count_reg;
                        res_next.prime_count = count_reg;
                        res_next.is_prime    = 1'b0;
                        res_next.status      = psc_pkg::STATUS_OK;
                        state_next           = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            built_reg       <= 1'b0;
            built_limit_reg <= '0;
            last_count_reg  <= '0;
            pend_reg        <= 1'b0;
        end else begin
            state_reg       <= state_next;
            built_reg       <= built_next;
            built_limit_reg <= built_limit_next;
            last_count_reg  <= last_count_next;
            pend_reg        <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        limit_reg <= limit_next;
        low_reg   <= low_next;
        count_reg <= count_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr[ADDR_W-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr[ADDR_W-1:0]];
        end
    end

    `PSC_ASSERT(a_start_when_idle, aclk, aresetn, start |-> state_reg == ST_IDLE)
    `PSC_ASSERT(a_error_not_prime, aclk, aresetn,
        (res_valid && res.status != psc_pkg::STATUS_OK) |-> !res.is_prime)
    `PSC_ASSERT_NEVER(a_write_in_limit, aclk, aresetn, mem_we && (mem_waddr > limit_ext))

endmodule
